// File: hdl/assert_macros.svh
// Assertion macros for the checker file kmsd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KMSD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define KMSD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/kmsd_pkg.sv
// ----------------------------------------------------------------------------
// kmsd_pkg
// Types, constants and the keymap of the keypad matrix scan/debounce core.
// ----------------------------------------------------------------------------
`default_nettype none

package kmsd_pkg;

    localparam int ROW_W      = 4;
    localparam int TICK_W     = 32;
    localparam int KEY_W      = 5;
    localparam int NCOL_W     = 3;
    localparam int DEB_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int MAX_EVENTS = 4;
    localparam int EVT_CNT_W  = 3;
    localparam int EVT_IDX_W  = 2;
    localparam int MAP_SIZE   = 24;

    localparam logic [KEY_W-1:0] KEY_UNMAPPED = 5'd22;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_EVENTS   = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [ROW_W-1:0]  row_bits;
        logic [TICK_W-1:0] tick_now;
    } t_in;

    typedef struct packed {
        logic              event_valid;
        logic [KEY_W-1:0]  key_code;
        logic              pressed;
        logic [NCOL_W-1:0] next_column;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key_code;
        logic             pressed;
    } t_evt;

    typedef struct packed {
        logic [EVT_CNT_W-1:0]        num_evt;
        t_evt [MAX_EVENTS-1:0]       evt;
    } t_step_res;

    localparam logic [KEY_W-1:0] KEYMAP [MAP_SIZE] = '{
        5'd0,  5'd4,  5'd8,  5'd12,
        5'd1,  5'd5,  5'd9,  5'd13,
        5'd2,  5'd6,  5'd10, 5'd14,
        5'd3,  5'd7,  5'd11, 5'd15,
        5'd16, 5'd17, 5'd18, 5'd19,
        5'd20, 5'd21, 5'd22, 5'd22
    };

    // Position is col * rows + row; anything past the table is invalid.
    function automatic logic [KEY_W-1:0] key_at(input logic [7:0] pos);
        logic [KEY_W-1:0] k;
        if (pos >= 8'(MAP_SIZE)) begin
            k = KEY_UNMAPPED;
        end else begin
            k = KEYMAP[pos[4:0]];
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hdl/kmsd_step.sv
// ----------------------------------------------------------------------------
// kmsd_step
// Row walk of one column read: debounce, status update and event list.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsd_step #(
    parameter int NUM_ROWS = 4,
    parameter int NUM_COLS = 6,
    localparam int CW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1
) (
    input  wire logic [CW-1:0]                   i_col,
    input  wire logic [NUM_ROWS-1:0]             i_status,
    input  wire logic [kmsd_pkg::KEY_W-1:0]      i_last_key,
    input  wire logic [kmsd_pkg::TICK_W-1:0]     i_last_time,
    input  wire kmsd_pkg::t_in                   i_item,
    input  wire logic [kmsd_pkg::DEB_W-1:0]      i_debounce,
    input  wire logic                            i_events_en,
    output logic [NUM_ROWS-1:0]                  o_status,
    output logic [kmsd_pkg::KEY_W-1:0]           o_last_key,
    output logic [kmsd_pkg::TICK_W-1:0]          o_last_time,
    output logic [CW-1:0]                        o_next_col,
    output kmsd_pkg::t_step_res                  o_res
);

    always_comb begin
        logic [7:0]                      rows8;
        logic [7:0]                      col8;
        logic [7:0]                      pos;
        logic [NUM_ROWS-1:0]             stat;
        logic [kmsd_pkg::KEY_W-1:0]      lk;
        logic [kmsd_pkg::KEY_W-1:0]      key;
        logic [kmsd_pkg::TICK_W-1:0]     lt;
        logic [kmsd_pkg::TICK_W-1:0]     diff;
        logic                            done_orig;
        logic                            done;
        logic                            acc;
        logic                            pin;
        kmsd_pkg::t_step_res             res;

        rows8 = {4'b0000, i_item.row_bits};
        col8  = 8'(i_col);
        stat  = i_status;
        lk    = i_last_key;
        lt    = i_last_time;
        acc   = 1'b0;
        res   = '0;
        pos   = '0;
        key   = '0;
        done  = 1'b0;
        pin   = 1'b0;
        diff  = i_item.tick_now - i_last_time;
        done_orig = !diff[kmsd_pkg::TICK_W-1] &&
                    (diff >= {{(kmsd_pkg::TICK_W-kmsd_pkg::DEB_W){1'b0}}, i_debounce});

        for (int r = 0; r < NUM_ROWS; r++) begin
            pin = rows8[r];
            if (stat[r] != pin) begin
                pos = 8'(col8 * 8'(NUM_ROWS)) + 8'(r);
                key = kmsd_pkg::key_at(pos);
                // after an earlier accept in this read the time difference is zero
                done = acc ? (i_debounce == '0) : done_orig;
                if (key != lk || done) begin
                    lk  = key;
                    lt  = i_item.tick_now;
                    acc = 1'b1;
                    if (i_events_en && res.num_evt < 3'(kmsd_pkg::MAX_EVENTS)) begin
                        res.evt[res.num_evt[kmsd_pkg::EVT_IDX_W-1:0]].key_code = key;
                        res.evt[res.num_evt[kmsd_pkg::EVT_IDX_W-1:0]].pressed  = pin;
                        res.num_evt = res.num_evt + 3'd1;
                    end
                    stat[r] = pin;
                end
            end
        end

        o_status    = stat;
        o_last_key  = lk;
        o_last_time = lt;
        o_res       = res;
        o_next_col  = (i_col == CW'(NUM_COLS - 1)) ? '0 : i_col + CW'(1);
    end

endmodule

`default_nettype wire

// File: hdl/keypad_matrix_scan_debounce_core.sv
// ----------------------------------------------------------------------------
// keypad_matrix_scan_debounce_core
// Keypad matrix scanner with per-key debounce and up to four events per read.
// ----------------------------------------------------------------------------
// An item is registered at acceptance, then moves into the result buffer when
//   that is free and its first result is shown. Throughput: max(1, events) results
//   per item, at most four events; the input register takes the next item meanwhile;
//   the single result buffer gives one result per cycle unless stalled.
// Reset (synchronous, active low): column status, column, last key and last
//   change time cleared, registers back to debounce 4 and events off.
`default_nettype none

module keypad_matrix_scan_debounce_core #(
    parameter int NUM_ROWS = 4,
    parameter int NUM_COLS = 6
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire kmsd_pkg::t_in                     i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output kmsd_pkg::t_out                         o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [kmsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [kmsd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

    // configuration
    logic [kmsd_pkg::DEB_W-1:0] r_debounce;
    logic                       r_events_en;

    // scan state
    logic [NUM_ROWS-1:0]            r_status [NUM_COLS];
    logic [CW-1:0]                  r_col;
    logic [kmsd_pkg::KEY_W-1:0]     r_last_key;
    logic [kmsd_pkg::TICK_W-1:0]    r_last_time;

    // input register
    logic                           r_in_valid;
    kmsd_pkg::t_in                  r_in;

    // result buffer
    logic                                               r_buf_valid;
    kmsd_pkg::t_evt [kmsd_pkg::MAX_EVENTS-1:0]          r_evt;
    logic [kmsd_pkg::EVT_CNT_W-1:0]                     r_nevt;
    logic [kmsd_pkg::EVT_IDX_W-1:0]                     r_idx;
    logic [kmsd_pkg::NCOL_W-1:0]                        r_ncol;

    logic [CW-1:0]                  col_g;
    logic [NUM_ROWS-1:0]            n_status;
    logic [kmsd_pkg::KEY_W-1:0]     n_last_key;
    logic [kmsd_pkg::TICK_W-1:0]    n_last_time;
    logic [CW-1:0]                  n_col;
    kmsd_pkg::t_step_res            step_res;

    logic                           has_evt;
    logic [kmsd_pkg::EVT_IDX_W-1:0] last_idx;
    logic                           is_last;
    logic                           out_take;
    logic                           buf_free;
    logic                           load;
    logic                           in_take;

    assign col_g = (int'(r_col) >= NUM_COLS) ? '0 : r_col;

    kmsd_step #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_step (
        .i_col       (col_g),
        .i_status    (r_status[col_g]),
        .i_last_key  (r_last_key),
        .i_last_time (r_last_time),
        .i_item      (r_in),
        .i_debounce  (r_debounce),
        .i_events_en (r_events_en),
        .o_status    (n_status),
        .o_last_key  (n_last_key),
        .o_last_time (n_last_time),
        .o_next_col  (n_col),
        .o_res       (step_res)
    );

    assign has_evt  = (r_nevt != '0);
    assign last_idx = has_evt ? kmsd_pkg::EVT_IDX_W'(r_nevt - 3'd1) : '0;
    assign is_last  = (r_idx == last_idx);
    assign out_take = r_buf_valid && !i_out_stall;
    assign buf_free = !r_buf_valid || (out_take && is_last);
    assign load     = r_in_valid && buf_free;
    assign in_take  = i_in_valid && !o_in_stall;

    assign o_in_stall  = r_in_valid && !buf_free;
    assign o_out_valid = r_buf_valid;

    always_comb begin
        o_out.event_valid = has_evt;
        o_out.key_code    = has_evt ? r_evt[r_idx].key_code : '0;
        o_out.pressed     = has_evt ? r_evt[r_idx].pressed : 1'b0;
        o_out.next_column = r_ncol;
        o_out.last        = is_last;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= 8'd4;
            r_events_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kmsd_pkg::CFG_DEBOUNCE: r_debounce  <= i_cfg_data;
                kmsd_pkg::CFG_EVENTS:   r_events_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // scan state, updated when an item moves into the result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                r_status[c] <= '0;
            end
            r_col       <= '0;
            r_last_key  <= '0;
            r_last_time <= '0;
        end else if (load) begin
            r_status[col_g] <= n_status;
            r_col           <= n_col;
            r_last_key      <= n_last_key;
            r_last_time     <= n_last_time;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_buf_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_buf_valid <= 1'b1;
                r_idx       <= '0;
            end else if (out_take) begin
                if (is_last) begin
                    r_buf_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + kmsd_pkg::EVT_IDX_W'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
        if (load) begin
            r_evt  <= step_res.evt;
            r_nevt <= step_res.num_evt;
            r_ncol <= kmsd_pkg::NCOL_W'(n_col);
        end
    end

endmodule

`default_nettype wire

// File: hdl/kmsd_checker.sv
// ----------------------------------------------------------------------------
// kmsd_checker
// Port-level checks on the result channel of the scan/debounce core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kmsd_checker #(
    parameter int NUM_COLS = 6
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_out_valid,
    input wire logic           i_out_stall,
    input wire kmsd_pkg::t_out i_out
);

    `KMSD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out), "stalled result changed")

    `KMSD_ASSERT_IMP(a_idle_last, i_clk, i_rst_n, i_out_valid && !i_out.event_valid, i_out.last, "result without event is not last")

    `KMSD_ASSERT_IMP(a_idle_zero, i_clk, i_rst_n, i_out_valid && !i_out.event_valid, i_out.key_code == 5'd0 && !i_out.pressed, "result without event has payload")

    `KMSD_ASSERT_IMP(a_key_range, i_clk, i_rst_n, i_out_valid && i_out.event_valid, i_out.key_code <= kmsd_pkg::KEY_UNMAPPED, "key code out of range")

    `KMSD_ASSERT_IMP(a_col_range, i_clk, i_rst_n, i_out_valid, (NUM_COLS > 8) || (int'(i_out.next_column) < NUM_COLS), "next column out of range")

endmodule

bind keypad_matrix_scan_debounce_core kmsd_checker #(
    .NUM_COLS (NUM_COLS)
) u_kmsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

`default_nettype wire
